>>> design/dge_pkg.sv
// package for the dual-gradient pixel energy core
// holds store geometry, field widths, state codes and datapath control struct
// no dependencies
`default_nettype none

package dge_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int SQ_W     = 2 * CHAN_W;
  localparam int PAIR_W   = SQ_W + 2;
  localparam int ENERGY_W = PAIR_W + 1;
  localparam int CFG_W    = 9;

  localparam logic [CFG_W-1:0] WIDTH_MIN  = CFG_W'(3);
  localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_MIN = CFG_W'(2);
  localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(MAX_HEIGHT);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_R,
    S_RD_U,
    S_RD_D,
    S_RD_LAST,
    S_SUM,
    S_ERR
  } state_t;

  typedef struct packed {
    logic first;
    logic second;
    logic load;
  } energy_ctl_t;

endpackage

`default_nettype wire

>>> design/dge_pixel_ram.sv
// pixel memory: one write port, one registered read port
// depends on dge_pkg for depth and pixel width
`default_nettype none

module dge_pixel_ram (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [dge_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [dge_pkg::PIX_W-1:0]  wr_data,
  input  wire logic [dge_pkg::ADDR_W-1:0] rd_addr,
  output logic      [dge_pkg::PIX_W-1:0]  rd_data
);

  logic [dge_pkg::PIX_W-1:0] mem [dge_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/dge_energy_unit.sv
// squared-difference datapath: pairs neighbor pixels and accumulates energy
// depends on dge_pkg for widths and the control struct
`default_nettype none

module dge_energy_unit (
  input  wire logic                         clk,
  input  wire dge_pkg::energy_ctl_t         ctl,
  input  wire logic [dge_pkg::PIX_W-1:0]    pix,
  output logic      [dge_pkg::ENERGY_W-1:0] total
);

  logic [dge_pkg::PIX_W-1:0]  first_pix;
  logic [dge_pkg::SQ_W-1:0]   sq [3];
  logic [dge_pkg::PAIR_W-1:0] acc;
  logic [dge_pkg::PAIR_W-1:0] sq_sum;

  function automatic logic [dge_pkg::SQ_W-1:0] sq_diff(
    input logic [dge_pkg::CHAN_W-1:0] a,
    input logic [dge_pkg::CHAN_W-1:0] b
  );
    logic [dge_pkg::CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return dge_pkg::SQ_W'(d) * dge_pkg::SQ_W'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.first) begin
      first_pix <= pix;
    end
    if (ctl.second) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= sq_diff(first_pix[i*dge_pkg::CHAN_W +: dge_pkg::CHAN_W],
                         pix[i*dge_pkg::CHAN_W +: dge_pkg::CHAN_W]);
      end
    end
    if (ctl.load) begin
      acc <= sq_sum;
    end
  end

  assign sq_sum = dge_pkg::PAIR_W'(sq[0]) + dge_pkg::PAIR_W'(sq[1])
                + dge_pkg::PAIR_W'(sq[2]);
  assign total  = dge_pkg::ENERGY_W'(acc) + dge_pkg::ENERGY_W'(sq_sum);

endmodule

`default_nettype wire

>>> design/dual_gradient_pixel_energy_core.sv
// dual-gradient pixel energy core: pixel store, neighbor read sequencer, output register
// depends on dge_pkg, dge_pixel_ram and dge_energy_unit
// sequence: an in-range query reads its left, right, above and below neighbors, then sums;
//   one outside the image skips the reads; a write takes effect at its acceptance edge
// throughput: one write per cycle while idle; input stalls from a query's acceptance
//   until its result loads; the four neighbor reads share the pixel memory's single read port
// reset: idle, output empty, image 256 x 256; pixel memory is not cleared
`default_nettype none

module dual_gradient_pixel_energy_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [dge_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         func,
  input  wire logic [7:0]                   column,
  input  wire logic [7:0]                   row_index,
  input  wire logic [7:0]                   red,
  input  wire logic [7:0]                   green,
  input  wire logic [7:0]                   blue,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [dge_pkg::ENERGY_W-1:0] energy,
  output logic                              out_of_range
);

  dge_pkg::state_t state, state_next;

  logic [dge_pkg::CFG_W-1:0] image_width;
  logic [dge_pkg::CFG_W-1:0] image_height;
  logic [dge_pkg::COL_W-1:0] col_q;
  logic [dge_pkg::ROW_W-1:0] row_q;

  logic                         accept;
  logic                         in_image;
  logic                         out_free;
  logic                         load_out;
  logic [dge_pkg::ENERGY_W-1:0] energy_next;
  logic                         oor_next;

  logic                         wr_en;
  logic [dge_pkg::ADDR_W-1:0]   rd_addr;
  logic [dge_pkg::PIX_W-1:0]    rd_data;
  logic [dge_pkg::COL_W-1:0]    left_in;
  logic [dge_pkg::COL_W-1:0]    right_q;
  logic [dge_pkg::ROW_W-1:0]    above_q;
  logic [dge_pkg::ROW_W-1:0]    below_q;
  logic [dge_pkg::ENERGY_W-1:0] total;
  dge_pkg::energy_ctl_t         ctl;

  assign in_stall = (state != dge_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (func == dge_pkg::FUNC_WRITE);
  assign out_free = !out_valid || !out_stall;
  assign in_image = ({1'b0, column} < image_width) && ({1'b0, row_index} < image_height);

  // wrapped neighbor positions
  assign left_in = (column == '0) ? dge_pkg::COL_W'(image_width - 1'b1) : column - 1'b1;
  assign right_q = ((dge_pkg::CFG_W'(col_q) + 1'b1) == image_width) ? '0 : col_q + 1'b1;
  assign above_q = ((dge_pkg::CFG_W'(row_q) + 1'b1) == image_height) ? '0 : row_q + 1'b1;
  assign below_q = (row_q == '0) ? dge_pkg::ROW_W'(image_height - 1'b1) : row_q - 1'b1;

  dge_pixel_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({row_index, column}),
    .wr_data ({red, green, blue}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dge_energy_unit u_energy (
    .clk   (clk),
    .ctl   (ctl),
    .pix   (rd_data),
    .total (total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dge_pkg::WIDTH_MAX;
      image_height <= dge_pkg::HEIGHT_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        dge_pkg::REG_IMAGE_WIDTH: begin
          image_width <= (cfg_data < dge_pkg::WIDTH_MIN) ? dge_pkg::WIDTH_MIN :
                         (cfg_data > dge_pkg::WIDTH_MAX) ? dge_pkg::WIDTH_MAX : cfg_data;
        end
        dge_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= (cfg_data < dge_pkg::HEIGHT_MIN) ? dge_pkg::HEIGHT_MIN :
                          (cfg_data > dge_pkg::HEIGHT_MAX) ? dge_pkg::HEIGHT_MAX : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dge_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= column;
      row_q <= row_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      energy       <= energy_next;
      out_of_range <= oor_next;
    end
  end

  always_comb begin
    state_next  = state;
    rd_addr     = {row_index, left_in};
    ctl         = '0;
    load_out    = 1'b0;
    energy_next = total;
    oor_next    = 1'b0;
    case (state)
      dge_pkg::S_IDLE: begin
        if (accept && (func == dge_pkg::FUNC_QUERY)) begin
          state_next = in_image ? dge_pkg::S_RD_R : dge_pkg::S_ERR;
        end
      end
      dge_pkg::S_RD_R: begin
        rd_addr    = {row_q, right_q};
        ctl.first  = 1'b1;
        state_next = dge_pkg::S_RD_U;
      end
      dge_pkg::S_RD_U: begin
        rd_addr    = {above_q, col_q};
        ctl.second = 1'b1;
        state_next = dge_pkg::S_RD_D;
      end
      dge_pkg::S_RD_D: begin
        rd_addr    = {below_q, col_q};
        ctl.first  = 1'b1;
        ctl.load   = 1'b1;
        state_next = dge_pkg::S_RD_LAST;
      end
      dge_pkg::S_RD_LAST: begin
        ctl.second = 1'b1;
        state_next = dge_pkg::S_SUM;
      end
      dge_pkg::S_SUM: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = dge_pkg::S_IDLE;
        end
      end
      dge_pkg::S_ERR: begin
        energy_next = '0;
        oor_next    = 1'b1;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = dge_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dge_pkg::S_IDLE;
      end
    endcase
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result loaded over an untaken result");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == dge_pkg::S_IDLE))
    else $error("pixel write outside idle");

  a_query_starts_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == dge_pkg::FUNC_QUERY) && in_image) |=> (state == dge_pkg::S_RD_R))
    else $error("in-range query did not start neighbor reads");

  a_error_energy_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (energy == '0))
    else $error("out-of-range result with nonzero energy");

endmodule

`default_nettype wire
